// File: hw/rtl/dram_refresh_scheduler_unit_macros.svh
// Assertion macros for the refresh scheduler.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef DRAM_REFRESH_SCHEDULER_UNIT_MACROS_SVH
`define DRAM_REFRESH_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication check
`define DRSU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define DRSU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/drs_pkg.sv
// Shared types and constants of the refresh scheduler.
// Used by drs_front, drs_back, drs_outq and the top level; depends on nothing.
`default_nettype none

package drs_pkg;

  localparam int CYC_W          = 48;
  localparam int BANK_COUNT_DEF = 16;
  localparam int ROW_LIMIT      = 8192;

  localparam logic [3:0]  MAX_POSTPONES = 4'd8;
  localparam logic [15:0] BASE_RESET    = 16'd12480;

  // Temperature thresholds in sixteenths of a degree
  localparam logic signed [12:0] TEMP_NORM_LIMIT = 13'sd1360;
  localparam logic signed [12:0] TEMP_EXT_MAX    = 13'sd1520;

  // Reciprocal for a divide by ten of a 16-bit value
  localparam logic [16:0] WIN_MUL   = 17'd52429;
  localparam int          WIN_SHIFT = 19;

  // Operation codes
  localparam logic [2:0] OP_POLL     = 3'd0;
  localparam logic [2:0] OP_COMPLETE = 3'd1;
  localparam logic [2:0] OP_POSTPONE = 3'd2;
  localparam logic [2:0] OP_RETAIN   = 3'd3;
  localparam logic [2:0] OP_TEMP     = 3'd4;

  // Register indexes
  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_MODE = 2'd1;
  localparam logic [1:0] CFG_PROF = 2'd2;

  // Refresh modes
  localparam logic [2:0] MODE_ALL = 3'd0;
  localparam logic [2:0] MODE_FG1 = 3'd2;
  localparam logic [2:0] MODE_FG2 = 3'd3;
  localparam logic [2:0] MODE_FG4 = 3'd4;

  // Thermal ranges
  localparam logic [1:0] RANGE_NORMAL = 2'd0;
  localparam logic [1:0] RANGE_EXT    = 2'd1;
  localparam logic [1:0] RANGE_HOT    = 2'd2;

  typedef enum logic [2:0] {
    CMD_POLL, CMD_COMPLETE, CMD_POSTPONE, CMD_RETAIN, CMD_TEMP, CMD_NONE
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [47:0]       cycle;
    logic [3:0]        bank;
    logic              all_banks;
    logic [12:0]       row;
    logic [47:0]       retention;
    logic signed [12:0] temperature;
  } item_t;

  typedef struct packed {
    logic        issued;
    logic        any_due;
    logic [3:0]  target_bank;
    logic        all_bank_cmd;
    logic [47:0] deadline;
    logic [7:0]  urgency;
    logic        postponed;
    logic [31:0] refresh_count;
    logic [31:0] postpone_total;
    logic [19:0] max_postpone_span;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/drs_front.sv
// Front end: two-entry request queue that decodes the operation code.
// Depends on drs_pkg.
`default_nettype none

module drs_front import drs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         operation,
  input  wire logic [47:0]        cycle,
  input  wire logic [3:0]         bank,
  input  wire logic               all_banks,
  input  wire logic [12:0]        row,
  input  wire logic [47:0]        retention,
  input  wire logic signed [12:0] temperature,
  output logic                    cmd_valid,
  output item_t                   cmd_item,
  input  wire logic               cmd_pop
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      dec;
  logic       do_push;
  logic       do_pop;

  // Classify the request
  always_comb begin
    dec.cycle       = cycle;
    dec.bank        = bank;
    dec.all_banks   = all_banks;
    dec.row         = row;
    dec.retention   = retention;
    dec.temperature = temperature;
    case (operation)
      OP_POLL:     dec.cmd = CMD_POLL;
      OP_COMPLETE: dec.cmd = CMD_COMPLETE;
      OP_POSTPONE: dec.cmd = CMD_POSTPONE;
      OP_RETAIN:   dec.cmd = CMD_RETAIN;
      OP_TEMP:     dec.cmd = CMD_TEMP;
      default:     dec.cmd = CMD_NONE;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_item  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Hold decoded requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= dec;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/drs_outq.sv
// Result queue: two entries between the engine and the result ports.
// Depends on drs_pkg.
`default_nettype none

module drs_outq import drs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_push,
  input  result_t      res_item,
  output logic         res_full,
  output logic         empty,
  input  wire logic    pop,
  output result_t      head
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = mem[rd_ptr];
  assign do_pop   = pop && !empty;

  // Hold results
  always_ff @(posedge clk) begin
    if (res_push) begin
      mem[wr_ptr] <= res_item;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= !wr_ptr;
      if (do_pop)   rd_ptr <= !rd_ptr;
      count <= count + 2'(res_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/drs_back.sv
// Back end: per-bank refresh state and the sequencer that scans banks,
// divides for urgency and rearms. Depends on drs_pkg and the macros header.
`default_nettype none
`include "dram_refresh_scheduler_unit_macros.svh"

module drs_back import drs_pkg::*; #(
  parameter int BANK_COUNT = BANK_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  item_t            cmd_item,
  output logic             cmd_pop,
  input  wire logic        res_full,
  output logic             res_push,
  output result_t          res_item,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_POST_APPLY, S_POST_SPAN, S_DL, S_URG, S_X, S_DIV, S_DONE
  } state_t;

  state_t state;

  // Per-bank state
  logic [47:0] last_refresh  [BANK_COUNT];
  logic [47:0] next_refresh  [BANK_COUNT];
  logic [3:0]  postpone_count [BANK_COUNT];
  logic [47:0] min_retention [BANK_COUNT];
  logic [BANK_COUNT-1:0] in_progress;
  logic [BANK_COUNT-1:0] retention_seen;

  // Global state and registers
  logic [15:0] base_interval;
  logic [2:0]  refresh_mode;
  logic        profiling_enable;
  logic [15:0] interval;
  logic [1:0]  thermal_range;
  logic [31:0] refresh_counter;
  logic [31:0] postpone_counter;
  logic [19:0] max_span;

  // Working registers
  item_t          cur;
  result_t        res;
  logic [BW-1:0]  idx;
  logic [BW-1:0]  cand;
  logic           found;
  logic           due;
  logic           phase;
  logic [12:0]    window;
  logic signed [48:0] best;
  logic           p_skip;
  logic           p_pc_ok;
  logic           p_chk;
  logic signed [48:0] p_slack;
  logic [52:0]    p_lhs;
  logic [51:0]    p_rhs;
  logic [47:0]    dl;
  logic [47:0]    diff;
  logic           overdue;
  logic [23:0]    rem;
  logic [7:0]     quo;
  logic [2:0]     step;

  logic           start;
  logic           last_idx;
  logic [13:0]    quarter;
  logic           quarter_big;
  logic           bank_ok;
  logic [BW-1:0]  bank_idx;
  logic [32:0]    win_prod;
  logic [1:0]     t_range;
  logic           hit_due;
  logic           poll_take;
  logic [47:0]    since;
  logic [48:0]    since_q;
  logic           post_take;
  logic [55:0]    x56;
  logic [23:0]    trial;
  logic [7:0]     quo_next;
  logic [17:0]    span_prod;
  logic [19:0]    span;

  assign start       = (state == S_IDLE) && cmd_valid && !res_full;
  assign cmd_pop     = start;
  assign last_idx    = (idx == BW'(BANK_COUNT - 1));
  assign quarter     = interval[15:2];
  assign quarter_big = 19'(quarter) > {base_interval, 3'b000};
  assign bank_ok     = 7'(cmd_item.bank) < 7'(BANK_COUNT);
  assign bank_idx    = BW'(cmd_item.bank);
  assign win_prod    = 33'(interval) * 33'(WIN_MUL);
  assign hit_due     = cur.cycle >= next_refresh[idx];
  assign poll_take   = !found && !in_progress[idx] && hit_due;
  assign since       = cur.cycle - last_refresh[idx];
  assign since_q     = {1'b0, since} + 49'(quarter);
  assign post_take   = !p_skip && (p_slack <= $signed(49'(window))) && p_pc_ok &&
                       !quarter_big && !(p_chk && ({1'b0, p_rhs} < p_lhs)) &&
                       (!found || (p_slack < best));
  assign x56         = {diff, 8'b0} - {8'b0, diff};
  assign trial       = 24'(interval) << step;
  assign span_prod   = 18'(postpone_count[cand]) * 18'(quarter);
  assign span        = 20'(span_prod);

  // Thermal range of the incoming temperature
  always_comb begin
    if (cmd_item.temperature <= TEMP_NORM_LIMIT) begin
      t_range = RANGE_NORMAL;
    end else if (cmd_item.temperature <= TEMP_EXT_MAX) begin
      t_range = RANGE_EXT;
    end else begin
      t_range = RANGE_HOT;
    end
  end

  // One restoring division step
  always_comb begin
    quo_next = quo;
    if (rem >= trial) quo_next[step] = 1'b1;
  end

  // Result with the counters as they stand
  always_comb begin
    res_item                   = res;
    res_item.refresh_count     = refresh_counter;
    res_item.postpone_total    = postpone_counter;
    res_item.max_postpone_span = max_span;
  end

  assign res_push = (state == S_DONE);

  // Sequencer, bank state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      base_interval    <= BASE_RESET;
      refresh_mode     <= MODE_ALL;
      profiling_enable <= 1'b0;
      interval         <= BASE_RESET;
      thermal_range    <= RANGE_NORMAL;
      refresh_counter  <= '0;
      postpone_counter <= '0;
      max_span         <= '0;
      in_progress      <= '0;
      retention_seen   <= '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
        last_refresh[b]   <= '0;
        next_refresh[b]   <= 48'(BASE_RESET);
        postpone_count[b] <= '0;
        min_retention[b]  <= '1;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur   <= cmd_item;
            res   <= '0;
            idx   <= '0;
            found <= 1'b0;
            due   <= 1'b0;
            phase <= 1'b0;
            case (cmd_item.cmd)
              CMD_POLL: begin
                state <= S_SCAN;
              end
              CMD_COMPLETE: begin
                refresh_counter <= refresh_counter + 32'd1;
                if (cmd_item.all_banks) begin
                  state <= S_SCAN;
                end else begin
                  if (bank_ok) begin
                    last_refresh[bank_idx]   <= cmd_item.cycle;
                    next_refresh[bank_idx]   <= cmd_item.cycle + 48'(interval);
                    in_progress[bank_idx]    <= 1'b0;
                    postpone_count[bank_idx] <= '0;
                  end
                  state <= S_DONE;
                end
              end
              CMD_POSTPONE: begin
                window <= 13'(win_prod >> WIN_SHIFT);
                state  <= S_SCAN;
              end
              CMD_RETAIN: begin
                if (profiling_enable && bank_ok &&
                    (17'(cmd_item.row) < 17'(ROW_LIMIT))) begin
                  if (!retention_seen[bank_idx] ||
                      (cmd_item.retention < min_retention[bank_idx])) begin
                    min_retention[bank_idx] <= cmd_item.retention;
                  end
                  retention_seen[bank_idx] <= 1'b1;
                end
                state <= S_DONE;
              end
              CMD_TEMP: begin
                if (t_range != thermal_range) begin
                  thermal_range <= t_range;
                  interval      <= base_interval >> t_range;
                  state         <= S_SCAN;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_SCAN: begin
          case (cur.cmd)
            CMD_POLL: begin
              if (hit_due) due <= 1'b1;
              if (poll_take) begin
                found <= 1'b1;
                cand  <= idx;
              end
              if (last_idx) begin
                res.any_due <= due || hit_due;
                state       <= (found || poll_take) ? S_DL : S_DONE;
              end else begin
                idx <= idx + BW'(1);
              end
            end
            CMD_POSTPONE: begin
              if (!phase) begin
                // Register slack and retention margin terms
                p_skip  <= in_progress[idx];
                p_slack <= $signed({1'b0, next_refresh[idx]}) - $signed({1'b0, cur.cycle});
                p_pc_ok <= postpone_count[idx] < MAX_POSTPONES;
                p_chk   <= profiling_enable && retention_seen[idx];
                p_lhs   <= {1'b0, since_q, 3'b000} + {3'b000, since_q, 1'b0};
                p_rhs   <= {4'b0000, min_retention[idx]} + {1'b0, min_retention[idx], 3'b000};
                phase   <= 1'b1;
              end else begin
                if (post_take) begin
                  found <= 1'b1;
                  cand  <= idx;
                  best  <= p_slack;
                end
                phase <= 1'b0;
                if (last_idx) begin
                  state <= (found || post_take) ? S_POST_APPLY : S_DONE;
                end else begin
                  idx <= idx + BW'(1);
                end
              end
            end
            CMD_COMPLETE: begin
              last_refresh[idx]   <= cur.cycle;
              next_refresh[idx]   <= cur.cycle + 48'(interval);
              in_progress[idx]    <= 1'b0;
              postpone_count[idx] <= '0;
              if (last_idx) state <= S_DONE;
              else idx <= idx + BW'(1);
            end
            CMD_TEMP: begin
              next_refresh[idx] <= last_refresh[idx] + 48'(interval);
              if (last_idx) state <= S_DONE;
              else idx <= idx + BW'(1);
            end
            default: state <= S_DONE;
          endcase
        end

        S_POST_APPLY: begin
          next_refresh[cand]   <= next_refresh[cand] + 48'(quarter);
          postpone_count[cand] <= postpone_count[cand] + 4'd1;
          postpone_counter     <= postpone_counter + 32'd1;
          res.postponed        <= 1'b1;
          res.target_bank      <= 4'(cand);
          state                <= S_POST_SPAN;
        end

        S_POST_SPAN: begin
          if (span > max_span) max_span <= span;
          state <= S_DONE;
        end

        S_DL: begin
          dl                <= next_refresh[cand] + 48'({base_interval, 3'b000});
          in_progress[cand] <= 1'b1;
          last_refresh[cand] <= cur.cycle;
          res.issued        <= 1'b1;
          res.target_bank   <= 4'(cand);
          res.all_bank_cmd  <= (refresh_mode == MODE_ALL);
          state             <= S_URG;
        end

        S_URG: begin
          res.deadline <= dl;
          overdue      <= cur.cycle >= dl;
          diff         <= dl - cur.cycle;
          state        <= S_X;
        end

        S_X: begin
          if (overdue) begin
            res.urgency <= 8'hFF;
            state       <= S_DONE;
          end else if (interval == '0) begin
            res.urgency <= 8'h00;
            state       <= S_DONE;
          end else if (x56 >= 56'({interval, 8'b0})) begin
            res.urgency <= 8'h00;
            state       <= S_DONE;
          end else begin
            rem   <= x56[23:0];
            quo   <= '0;
            step  <= 3'd7;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (rem >= trial) rem <= rem - trial;
          quo <= quo_next;
          if (step == 3'd0) begin
            res.urgency <= 8'hFF - quo_next;
            state       <= S_DONE;
          end else begin
            step <= step - 3'd1;
          end
        end

        S_DONE: begin
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase

      // Register writes are expected only while idle; this block does not enforce it
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE: base_interval <= cfg_data;
          CFG_MODE: begin
            if (cfg_data[2:0] != refresh_mode) begin
              refresh_mode <= cfg_data[2:0];
              case (cfg_data[2:0])
                MODE_FG1: interval <= base_interval;
                MODE_FG2: interval <= base_interval >> 1;
                MODE_FG4: interval <= base_interval >> 2;
                default:  interval <= interval;
              endcase
            end
          end
          CFG_PROF: profiling_enable <= cfg_data[0];
          default:  base_interval <= base_interval;
        endcase
      end
    end
  end

  `DRSU_ASSERT_IMP(a_issue_due, clk, rst, res_push && res_item.issued, res_item.any_due, "refresh issued with no bank due")
  `DRSU_ASSERT_IMP(a_issue_excl, clk, rst, res_push, !(res_item.issued && res_item.postponed), "issue and postpone in one result")
  `DRSU_ASSERT_NXT(a_start_busy, clk, rst, start, state != S_IDLE, "engine stayed idle after taking a request")

endmodule

`default_nettype wire

// File: hw/rtl/dram_refresh_scheduler_unit.sv
// Per-bank DRAM refresh scheduler, top level.
// Requests enter through a queue-like port (push/full); results leave through
// a queue-like port (empty/pop), one result per request, in request order.
// Register writes use cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready
// is always high, and writes are expected only while no request is in flight.
// A two-entry request queue decodes operations; the engine works on one
// request at a time; a two-entry result queue decouples the result side.
// Work in the engine per request:
//   retention sample, single-bank completion, temperature in the same
//   range, unknown operation: no further steps
//   all-bank completion, temperature change: a scan over all banks
//   postpone: a scan with a register and a compare phase per bank, then
//   apply and span steps when a bank is postponed
//   poll: a scan; when issued, deadline and urgency terms, then an 8-step
//   restoring divider for the urgency unless overdue or clipped
// Reset is synchronous: bank timers reload the base interval, counters clear,
// and both queues empty. When pop stays low the result queue fills, the
// engine waits, then the request queue fills and full rises.
`default_nettype none

module dram_refresh_scheduler_unit import drs_pkg::*; #(
  parameter int BANK_COUNT = BANK_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         operation,
  input  wire logic [47:0]        cycle,
  input  wire logic [3:0]         bank,
  input  wire logic               all_banks,
  input  wire logic [12:0]        row,
  input  wire logic [47:0]        retention,
  input  wire logic signed [12:0] temperature,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    issued,
  output logic                    any_due,
  output logic [3:0]              target_bank,
  output logic                    all_bank_cmd,
  output logic [47:0]             deadline,
  output logic [7:0]              urgency,
  output logic                    postponed,
  output logic [31:0]             refresh_count,
  output logic [31:0]             postpone_total,
  output logic [19:0]             max_postpone_span,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic    cmd_valid;
  item_t   cmd_item;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t res_item;
  result_t head;

  assign cfg_ready = 1'b1;

  drs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .cycle       (cycle),
    .bank        (bank),
    .all_banks   (all_banks),
    .row         (row),
    .retention   (retention),
    .temperature (temperature),
    .cmd_valid   (cmd_valid),
    .cmd_item    (cmd_item),
    .cmd_pop     (cmd_pop)
  );

  drs_back #(.BANK_COUNT(BANK_COUNT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_item (res_item),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  // Drive result ports from the queue head
  assign issued            = head.issued;
  assign any_due           = head.any_due;
  assign target_bank       = head.target_bank;
  assign all_bank_cmd      = head.all_bank_cmd;
  assign deadline          = head.deadline;
  assign urgency           = head.urgency;
  assign postponed         = head.postponed;
  assign refresh_count     = head.refresh_count;
  assign postpone_total    = head.postpone_total;
  assign max_postpone_span = head.max_postpone_span;

endmodule

`default_nettype wire
